// ===== rtl/ffsa_pkg.sv =====
// Package for the first-fit segment allocator.
// Holds status codes, field widths and parameter defaults; no dependencies.
`timescale 1ns / 1ps
package ffsa_pkg;

  localparam int unsigned MaxSegmentsDefault = 32;
  localparam int unsigned SizeBitsDefault    = 16;

  localparam int unsigned KindW   = 1;
  localparam int unsigned ReqW    = 16;
  localparam int unsigned PidW    = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned TotalW  = 16;
  localparam int unsigned CfgW    = 16;

  localparam logic [KindW-1:0] KindAlloc = 1'b0;
  localparam logic [KindW-1:0] KindFree  = 1'b1;

  localparam logic [StatusW-1:0] StAllocated = 3'd0;
  localparam logic [StatusW-1:0] StNoFit     = 3'd1;
  localparam logic [StatusW-1:0] StFreed     = 3'd2;
  localparam logic [StatusW-1:0] StNotFound  = 3'd3;
  localparam logic [StatusW-1:0] StTableFull = 3'd4;

  localparam logic [CfgW-1:0] TotalUnitsReset = 16'd1024;

endpackage

// ===== rtl/ffsa_if.sv =====
// Valid/ready channel interfaces for the first-fit segment allocator.
// Request, result and configuration channels; depends on ffsa_pkg.
`timescale 1ns / 1ps
interface ffsa_req_if;
  logic                           valid;
  logic                           ready;
  logic [ffsa_pkg::KindW-1:0]     kind;
  logic [ffsa_pkg::ReqW-1:0]      request_size;
  logic [ffsa_pkg::PidW-1:0]      owner_id;
  modport source (output valid, kind, request_size, owner_id, input ready);
  modport sink   (input valid, kind, request_size, owner_id, output ready);
endinterface

interface ffsa_res_if;
  logic                           valid;
  logic                           ready;
  logic [ffsa_pkg::StatusW-1:0]   status;
  logic [ffsa_pkg::TotalW-1:0]    free_total;
  modport source (output valid, status, free_total, input ready);
  modport sink   (input valid, status, free_total, output ready);
endinterface

interface ffsa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ffsa_pkg::CfgW-1:0]      data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/first_fit_segment_allocator.sv =====
// First-fit segment allocator; depends on ffsa_pkg and ffsa_if.
// An allocate scans from index 0 for the first free segment that fits; an exact fit writes the hit
// entry, a split shifts the later entries up, then writes the remainder and the hit entry. A free
// merges the owner's first segment with free neighbours and copies the later entries down.
// Throughput: one transaction in flight; the next is accepted at the earliest at the edge that
// takes the result. Reset or a total_units write gives one free segment at once, no clearing pass.
`timescale 1ns / 1ps
module first_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MaxSegmentsDefault,
  parameter int unsigned SIZE_BITS    = ffsa_pkg::SizeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffsa_cfg_if.sink   cfg_i,
  ffsa_req_if.sink   req_i,
  ffsa_res_if.source res_o
);

  localparam int unsigned IdxW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned OwnW = ffsa_pkg::PidW;
  localparam int unsigned EntW = SIZE_BITS + 1 + OwnW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SPLIT  = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_RIGHT  = 3'd5;
  localparam logic [2:0] S_MERGE  = 3'd6;
  localparam logic [2:0] S_COPY   = 3'd7;

  logic [EntW-1:0] mem_q [MAX_SEGMENTS];
  logic [EntW-1:0] rdata_q;
  logic [IdxW-1:0] ra_q;
  logic [IdxW-1:0] rd_addr;
  logic            we;
  logic [IdxW-1:0] wa;
  logic [EntW-1:0] wd;

  logic [2:0]                    state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [CntW-1:0]               idx_q, idx_d;
  logic [CntW-1:0]               ptr_q, ptr_d;
  logic [IdxW-1:0]               hi_q, hi_d;
  logic [IdxW-1:0]               base_q, base_d;
  logic [SIZE_BITS-1:0]          hsz_q, hsz_d;
  logic [SIZE_BITS-1:0]          msz_q, msz_d;
  logic [SIZE_BITS-1:0]          psz_q, psz_d;
  logic                          pfree_q, pfree_d;
  logic [1:0]                    rem_q, rem_d;
  logic [SIZE_BITS-1:0]          total_q;
  logic [SIZE_BITS-1:0]          fsum_q, fsum_d;
  logic                          init_q, init_d;
  logic [ffsa_pkg::KindW-1:0]    kind_q;
  logic [SIZE_BITS-1:0]          req_q;
  logic [OwnW-1:0]               pid_q;
  logic                          out_valid_q;
  logic [ffsa_pkg::StatusW-1:0]  out_status_q;
  logic [SIZE_BITS-1:0]          out_total_q;

  logic                          fin;
  logic [ffsa_pkg::StatusW-1:0]  fin_status;
  logic [EntW-1:0]               ent;
  logic [SIZE_BITS-1:0]          ent_size;
  logic                          ent_free;
  logic [OwnW-1:0]               ent_owner;
  logic                          req_acc;
  logic                          cfg_acc;
  logic [CntW:0]                 nptr;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || res_o.ready);
  assign req_acc     = req_i.valid && req_i.ready;

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_status_q;
  assign res_o.free_total = ffsa_pkg::TotalW'(out_total_q);

  assign ent = (init_q && ra_q == '0) ? {total_q, 1'b1, {OwnW{1'b0}}} : rdata_q;
  assign ent_size  = ent[EntW-1 -: SIZE_BITS];
  assign ent_free  = ent[OwnW];
  assign ent_owner = ent[OwnW-1:0];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    ptr_d      = ptr_q;
    hi_d       = hi_q;
    base_d     = base_q;
    hsz_d      = hsz_q;
    msz_d      = msz_q;
    psz_d      = psz_q;
    pfree_d    = pfree_q;
    rem_d      = rem_q;
    fsum_d     = fsum_q;
    init_d     = init_q;
    rd_addr    = '0;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    fin        = 1'b0;
    fin_status = ffsa_pkg::StNoFit;
    nptr       = '0;
    case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          idx_d   = '0;
          pfree_d = 1'b0;
          psz_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = IdxW'(idx_q + 1'b1);
        if (idx_q >= count_q || (kind_q == ffsa_pkg::KindAlloc && req_q == '0)) begin
          fin        = 1'b1;
          fin_status = (kind_q == ffsa_pkg::KindAlloc) ? ffsa_pkg::StNoFit
                                                       : ffsa_pkg::StNotFound;
          state_d    = S_IDLE;
        end else if (kind_q == ffsa_pkg::KindAlloc) begin
          if (ent_free && ent_size >= req_q) begin
            hi_d  = IdxW'(idx_q);
            hsz_d = ent_size;
            if (ent_size == req_q) begin
              state_d = S_WRITE;
            end else if (count_q == CntW'(MAX_SEGMENTS)) begin
              fin        = 1'b1;
              fin_status = ffsa_pkg::StTableFull;
              state_d    = S_IDLE;
            end else if (count_q > idx_q + 1'b1) begin
              ptr_d   = count_q;
              rd_addr = IdxW'(count_q - 1'b1);
              state_d = S_SHIFT;
            end else begin
              state_d = S_SPLIT;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          if (!ent_free && ent_owner == pid_q) begin
            hi_d   = IdxW'(idx_q);
            fsum_d = fsum_q + ent_size;
            if (pfree_q && idx_q != '0) begin
              base_d = IdxW'(idx_q - 1'b1);
              msz_d  = ent_size + psz_q;
              rem_d  = 2'd1;
            end else begin
              base_d = IdxW'(idx_q);
              msz_d  = ent_size;
              rem_d  = 2'd0;
            end
            if (idx_q + 1'b1 < count_q) begin
              state_d = S_RIGHT;
            end else begin
              state_d = S_MERGE;
            end
          end else begin
            pfree_d = ent_free;
            psz_d   = ent_size;
            idx_d   = idx_q + 1'b1;
          end
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        wa    = IdxW'(ptr_q);
        wd    = ent;
        ptr_d = ptr_q - 1'b1;
        if (ptr_q - 1'b1 > CntW'(hi_q) + 1'b1) begin
          rd_addr = IdxW'(ptr_q - 2'd2);
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        we      = 1'b1;
        wa      = hi_q + 1'b1;
        wd      = {SIZE_BITS'(hsz_q - req_q), 1'b1, {OwnW{1'b0}}};
        count_d = count_q + 1'b1;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        we         = 1'b1;
        wa         = hi_q;
        wd         = {req_q, 1'b0, pid_q};
        fsum_d     = fsum_q - req_q;
        fin        = 1'b1;
        fin_status = ffsa_pkg::StAllocated;
        state_d    = S_IDLE;
      end
      S_RIGHT: begin
        if (ent_free) begin
          msz_d = msz_q + ent_size;
          rem_d = rem_q + 1'b1;
        end
        state_d = S_MERGE;
      end
      S_MERGE: begin
        we    = 1'b1;
        wa    = base_q;
        wd    = {msz_q, 1'b1, {OwnW{1'b0}}};
        ptr_d = CntW'(base_q) + 1'b1;
        nptr  = (CntW + 1)'(base_q) + 1'b1 + rem_q;
        if (rem_q == '0) begin
          fin        = 1'b1;
          fin_status = ffsa_pkg::StFreed;
          state_d    = S_IDLE;
        end else if (nptr < (CntW + 1)'(count_q)) begin
          rd_addr = IdxW'(nptr);
          state_d = S_COPY;
        end else begin
          count_d    = count_q - rem_q;
          fin        = 1'b1;
          fin_status = ffsa_pkg::StFreed;
          state_d    = S_IDLE;
        end
      end
      S_COPY: begin
        we    = 1'b1;
        wa    = IdxW'(ptr_q);
        wd    = ent;
        ptr_d = ptr_q + 1'b1;
        nptr  = (CntW + 1)'(ptr_q) + 1'b1 + rem_q;
        if (nptr < (CntW + 1)'(count_q)) begin
          rd_addr = IdxW'(nptr);
        end else begin
          count_d    = count_q - rem_q;
          fin        = 1'b1;
          fin_status = ffsa_pkg::StFreed;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (we && wa == '0) begin
      init_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CntW'(1);
      total_q     <= SIZE_BITS'(ffsa_pkg::TotalUnitsReset);
      fsum_q      <= SIZE_BITS'(ffsa_pkg::TotalUnitsReset);
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
      ra_q        <= '0;
    end else begin
      state_q <= state_d;
      ra_q    <= rd_addr;
      if (cfg_acc) begin
        total_q <= SIZE_BITS'(cfg_i.data);
        fsum_q  <= SIZE_BITS'(cfg_i.data);
        count_q <= CntW'(1);
        init_q  <= 1'b1;
      end else begin
        fsum_q  <= fsum_d;
        count_q <= count_d;
        init_q  <= init_d;
      end
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    ptr_q   <= ptr_d;
    hi_q    <= hi_d;
    base_q  <= base_d;
    hsz_q   <= hsz_d;
    msz_q   <= msz_d;
    psz_q   <= psz_d;
    pfree_q <= pfree_d;
    rem_q   <= rem_d;
    if (req_acc) begin
      kind_q <= req_i.kind;
      req_q  <= SIZE_BITS'(req_i.request_size);
      pid_q  <= req_i.owner_id;
    end
    if (fin) begin
      out_status_q <= fin_status;
      out_total_q  <= fsum_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CntW'(1) && count_q <= CntW'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_init_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q && state_q == S_IDLE |-> count_q == CntW'(1))
    else $error("table override active with more than one segment");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> state_q == S_SCAN)
    else $error("accepted transaction did not start a scan");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> state_q == S_IDLE && out_valid_q)
    else $error("finished transaction not presented");

endmodule

// ===== verif/first_fit_segment_allocator_test.sv =====
// Self-checking testbench for the first-fit segment allocator.
// Drives requests and total_units writes, predicts each result in a scoreboard
// class and checks it; depends on ffsa_pkg, ffsa_if and the allocator RTL.
`timescale 1ns / 1ps
module first_fit_segment_allocator_test;

  localparam int unsigned NumSeg   = ffsa_pkg::MaxSegmentsDefault;
  localparam int unsigned DrainGap = 2 * NumSeg + 20;

  typedef struct packed {
    logic [ffsa_pkg::StatusW-1:0] status;
    logic [ffsa_pkg::TotalW-1:0]  free_total;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [ffsa_pkg::ReqW-1:0] seg_size [NumSeg];
    bit                        seg_free [NumSeg];
    logic [ffsa_pkg::PidW-1:0] seg_owner[NumSeg];
    int unsigned               seg_count;
    logic [ffsa_pkg::ReqW-1:0] free_sum;
    alloc_result_t             expected_q[$];
    int unsigned               failures;

    function void reinit(logic [ffsa_pkg::CfgW-1:0] total);
      for (int k = 0; k < NumSeg; k++) begin
        seg_size[k]  = '0;
        seg_free[k]  = 1'b0;
        seg_owner[k] = '0;
      end
      seg_size[0] = total;
      seg_free[0] = 1'b1;
      seg_count   = 1;
      free_sum    = total;
    endfunction

    function void move_entry(int dst, int src);
      seg_size[dst]  = seg_size[src];
      seg_free[dst]  = seg_free[src];
      seg_owner[dst] = seg_owner[src];
    endfunction

    function logic [ffsa_pkg::StatusW-1:0] allocate(logic [ffsa_pkg::ReqW-1:0] req,
                                                    logic [ffsa_pkg::PidW-1:0] pid);
      int hit;
      hit = -1;
      if (req == '0) return ffsa_pkg::StNoFit;
      for (int k = 0; k < seg_count; k++) begin
        if (hit < 0 && seg_free[k] && seg_size[k] >= req) hit = k;
      end
      if (hit < 0) return ffsa_pkg::StNoFit;
      if (seg_size[hit] > req) begin
        if (seg_count >= NumSeg) return ffsa_pkg::StTableFull;
        for (int j = seg_count; j > hit + 1; j--) move_entry(j, j - 1);
        seg_size[hit+1]  = seg_size[hit] - req;
        seg_free[hit+1]  = 1'b1;
        seg_owner[hit+1] = '0;
        seg_count++;
      end
      seg_size[hit]  = req;
      seg_free[hit]  = 1'b0;
      seg_owner[hit] = pid;
      free_sum       = free_sum - req;
      return ffsa_pkg::StAllocated;
    endfunction

    function void merge_free();
      int k;
      k = 0;
      while (k + 1 < seg_count) begin
        if (seg_free[k] && seg_free[k+1]) begin
          seg_size[k] = seg_size[k] + seg_size[k+1];
          for (int j = k + 1; j + 1 < seg_count; j++) move_entry(j, j + 1);
          seg_count--;
          seg_size[seg_count]  = '0;
          seg_free[seg_count]  = 1'b0;
          seg_owner[seg_count] = '0;
        end else begin
          k++;
        end
      end
    endfunction

    function logic [ffsa_pkg::StatusW-1:0] release_owner(logic [ffsa_pkg::PidW-1:0] pid);
      for (int k = 0; k < seg_count; k++) begin
        if (!seg_free[k] && seg_owner[k] == pid) begin
          seg_free[k]  = 1'b1;
          seg_owner[k] = '0;
          free_sum     = free_sum + seg_size[k];
          merge_free();
          return ffsa_pkg::StFreed;
        end
      end
      return ffsa_pkg::StNotFound;
    endfunction

    function void note_request(logic [ffsa_pkg::KindW-1:0] kind,
                               logic [ffsa_pkg::ReqW-1:0] req,
                               logic [ffsa_pkg::PidW-1:0] pid);
      alloc_result_t r;
      if (kind == ffsa_pkg::KindAlloc) r.status = allocate(req, pid);
      else r.status = release_owner(pid);
      r.free_total = free_sum;
      expected_q.push_back(r);
    endfunction

    function void check(logic [ffsa_pkg::StatusW-1:0] status,
                        logic [ffsa_pkg::TotalW-1:0] free_total);
      alloc_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with nothing pending: status %0d free_total %0d", status, free_total);
        failures++;
        return;
      end
      r = expected_q.pop_front();
      if (status !== r.status) begin
        $error("status mismatch: expected %0d actual %0d", r.status, status);
        failures++;
      end
      if (free_total !== r.free_total) begin
        $error("free_total mismatch: expected %0d actual %0d", r.free_total, free_total);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ffsa_cfg_if cfg_if();
  ffsa_req_if req_if();
  ffsa_res_if res_if();

  first_fit_segment_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  alloc_scoreboard sb;
  logic [ffsa_pkg::CfgW-1:0] cur_total;
  bit hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result sink: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end else if ($urandom_range(0, 99) < 65) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b0;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 3);
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check(res_if.status, res_if.free_total);
  end

  task automatic send_request(logic [ffsa_pkg::KindW-1:0] kind,
                              logic [ffsa_pkg::ReqW-1:0] req,
                              logic [ffsa_pkg::PidW-1:0] pid, bit allow_gap);
    int gap;
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.request_size <= req;
    req_if.owner_id     <= pid;
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
    sb.note_request(kind, req, pid);
    if (allow_gap && $urandom_range(0, 99) < 30) begin
      req_if.valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainGap) @(posedge clk_i);
  endtask

  task automatic write_total(logic [ffsa_pkg::CfgW-1:0] total);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= total;
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    sb.reinit(total);
    cur_total = total;
  endtask

  task automatic send_random();
    logic [ffsa_pkg::KindW-1:0] kind;
    logic [ffsa_pkg::ReqW-1:0]  req;
    logic [ffsa_pkg::PidW-1:0]  pid;
    int unsigned                pick;
    int unsigned                span;
    kind = ($urandom_range(0, 99) < 55) ? ffsa_pkg::KindAlloc : ffsa_pkg::KindFree;
    pick = $urandom_range(0, 99);
    span = (cur_total / 20 > 1) ? cur_total / 20 : 1;
    if (pick < 70) req = ffsa_pkg::ReqW'($urandom_range(1, span));
    else if (pick < 85) req = ffsa_pkg::ReqW'($urandom_range(1, (cur_total > 1) ? cur_total : 1));
    else req = ffsa_pkg::ReqW'($urandom_range(1, 65535));
    pid = ($urandom_range(0, 99) < 85) ? ffsa_pkg::PidW'($urandom_range(0, 15))
                                       : ffsa_pkg::PidW'($urandom_range(0, 255));
    send_request(kind, req, pid, 1'b1);
  endtask

  initial begin
    logic [ffsa_pkg::CfgW-1:0] totals[5];
    sb = new();
    sb.reinit(ffsa_pkg::TotalUnitsReset);
    cur_total = ffsa_pkg::TotalUnitsReset;
    hold_off = 1'b0;
    totals = '{16'd65535, 16'd100, 16'd1024, 16'd1, 16'd5000};
    rst_ni              <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= '0;
    req_if.valid        <= 1'b0;
    req_if.kind         <= ffsa_pkg::KindAlloc;
    req_if.request_size <= '0;
    req_if.owner_id     <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(ffsa_pkg::KindAlloc, 16'd1, 8'd0, 1'b0);
    send_request(ffsa_pkg::KindAlloc, 16'd1023, 8'd255, 1'b0);
    send_request(ffsa_pkg::KindAlloc, 16'd1, 8'd7, 1'b0);
    send_request(ffsa_pkg::KindFree, 16'd0, 8'd5, 1'b0);
    send_request(ffsa_pkg::KindFree, 16'hffff, 8'd0, 1'b0);
    send_request(ffsa_pkg::KindFree, 16'd0, 8'd255, 1'b0);
    send_request(ffsa_pkg::KindAlloc, 16'hffff, 8'd9, 1'b0);
    send_request(ffsa_pkg::KindAlloc, 16'd1024, 8'd170, 1'b0);
    send_request(ffsa_pkg::KindFree, 16'd0, 8'd170, 1'b0);

    write_total(16'd65535);
    for (int k = 0; k < NumSeg; k++) begin
      send_request(ffsa_pkg::KindAlloc, 16'd1, k[ffsa_pkg::PidW-1:0], 1'b0);
    end
    send_request(ffsa_pkg::KindAlloc, ffsa_pkg::ReqW'(65535 - (NumSeg - 1)), 8'd85, 1'b0);

    write_total(16'd0);
    send_request(ffsa_pkg::KindAlloc, 16'd1, 8'd1, 1'b0);
    send_request(ffsa_pkg::KindFree, 16'd0, 8'd1, 1'b0);

    foreach (totals[p]) begin
      write_total(totals[p]);
      for (int n = 0; n < 230; n++) begin
        if (p == 0 && n == 50) hold_off = 1'b1;
        if (n == 120) drain();
        send_random();
      end
    end
    write_total(16'd0);
    for (int n = 0; n < 20; n++) send_random();

    drain();
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
